// ===== src/bezier_de_casteljau_sampler_unit_defines.svh =====
// Assertion macros for the Bezier sampler RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef BEZIER_DE_CASTELJAU_SAMPLER_UNIT_DEFINES_SVH
`define BEZIER_DE_CASTELJAU_SAMPLER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define BDC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define BDC_ASSERT_NORST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define BDC_ASSERT(label, clk, rst_n, prop, msg)
`define BDC_ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

// ===== src/bdc_pkg.sv =====
// Shared types and constants for the Bezier sampler.
// No dependencies.
package bdc_pkg;

    localparam int SEG_BITS      = 10;
    localparam int PC_BITS       = 5;
    localparam int SLOT_BITS     = 4;
    localparam int SAMPLE_BITS   = 10;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 10;
    localparam int STATUS_BITS   = 2;
    localparam int T_FRAC_BITS   = 16;
    localparam int T_BITS        = T_FRAC_BITS + 1;
    localparam int ONE_Q16       = 65536;
    localparam int DIV_STEPS     = SAMPLE_BITS + T_FRAC_BITS;
    localparam int DIV_CNT_BITS  = 5;
    localparam int SEG_RESET     = 16;

    localparam logic [CFG_IDX_BITS-1:0] CFG_SEGMENT_COUNT = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_POINT_COUNT   = 2'd1;

    typedef enum logic [STATUS_BITS-1:0] {
        STATUS_OK       = 2'd0,
        STATUS_NO_CURVE = 2'd1,
        STATUS_RANGE    = 2'd2
    } status_t;

    typedef enum logic {
        KIND_LOAD   = 1'b0,
        KIND_SAMPLE = 1'b1
    } kind_t;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_DIV    = 5'b00010,
        S_LEVEL  = 5'b00100,
        S_SINGLE = 5'b01000,
        S_FINISH = 5'b10000
    } state_t;

endpackage

// ===== src/bdc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bdc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/bezier_de_casteljau_sampler_unit.sv =====
// Load word: written to the control point store, no result. Sample word with
// n >= 2 points: t comes from the 26-step serial divider, then the single lerp
// pipeline makes one pass per level and drains before the level shrinks.
// Status-only answers and a single point skip both. One sample in flight.
// Reset clears control state: segment_count 16, point_count 0; the control
// point store is not cleared and holds garbage until loaded.
`include "bezier_de_casteljau_sampler_unit_defines.svh"

module bezier_de_casteljau_sampler_unit #(
    parameter int MAX_POINTS = 16,
    parameter int COORD_BITS = 24
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic                                  kind,
    input  logic [bdc_pkg::SLOT_BITS-1:0]         point_index,
    input  logic signed [COORD_BITS-1:0]          point_x,
    input  logic signed [COORD_BITS-1:0]          point_y,
    input  logic [bdc_pkg::SAMPLE_BITS-1:0]       sample_index,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [COORD_BITS-1:0]          curve_x,
    output logic signed [COORD_BITS-1:0]          curve_y,
    output logic [bdc_pkg::STATUS_BITS-1:0]       status,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [bdc_pkg::CFG_IDX_BITS-1:0]      cfg_index,
    input  logic [bdc_pkg::CFG_DATA_BITS-1:0]     cfg_data
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int DW = COORD_BITS + 1;
    localparam int PW = COORD_BITS + bdc_pkg::T_BITS + 2;
    localparam int RW = 2 * COORD_BITS;
    localparam logic signed [PW-1:0] ROUND_HALF = PW'(2 ** (bdc_pkg::T_FRAC_BITS - 1));

    // Control state
    bdc_pkg::state_t                    state_reg, state_next;
    logic [bdc_pkg::SEG_BITS-1:0]       seg_reg;
    logic [bdc_pkg::PC_BITS-1:0]        pc_reg;
    logic [CW-1:0]                      lvl_reg, lvl_next;
    logic [CW-1:0]                      rd_cnt_reg, rd_cnt_next;
    logic                               first_reg, first_next;
    logic [bdc_pkg::DIV_CNT_BITS-1:0]   div_cnt_reg, div_cnt_next;
    logic [bdc_pkg::DIV_STEPS-1:0]      dvd_reg, dvd_next;
    logic [bdc_pkg::SEG_BITS-1:0]       rem_reg, rem_next;
    logic                               v1_reg, v2_reg, v3_reg;
    logic                               out_valid_reg;

    // Datapath
    logic [AW-1:0]                      idx1_reg, idx2_reg, idx3_reg;
    logic signed [COORD_BITS-1:0]       ax_reg, ay_reg, ahx_reg, ahy_reg, ah2x_reg, ah2y_reg;
    logic signed [DW-1:0]               dx_reg, dy_reg;
    logic signed [PW-1:0]               px_reg, py_reg;
    logic signed [COORD_BITS-1:0]       last_x_reg, last_y_reg;
    logic signed [COORD_BITS-1:0]       res_x_reg, res_x_next, res_y_reg, res_y_next;
    bdc_pkg::status_t                   res_st_reg, res_st_next;
    logic signed [COORD_BITS-1:0]       out_x_reg, out_y_reg;
    bdc_pkg::status_t                   out_st_reg;

    logic                               in_acc;
    logic                               issue;
    logic                               slot_ok;
    logic                               deliver;
    logic [CW-1:0]                      n_use;
    logic [bdc_pkg::SEG_BITS:0]         rem_sh, rem_sub;
    logic                               q_bit;
    logic signed [bdc_pkg::T_BITS:0]    t_s;
    logic [RW-1:0]                      ctrl_rd, work_rd, src_rd, work_wr;
    logic [AW-1:0]                      ctrl_rd_addr;
    logic signed [COORD_BITS-1:0]       src_x, src_y, lerp_x, lerp_y;
    logic signed [PW-1:0]               sum_x, sum_y, wide_x, wide_y;

    assign in_stall  = (state_reg != bdc_pkg::S_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign slot_ok   = (int'(point_index) < MAX_POINTS);
    assign deliver   = (state_reg == bdc_pkg::S_FINISH) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        if (int'(pc_reg) > MAX_POINTS)
        begin
            n_use = CW'(MAX_POINTS);
        end
        else
        begin
            n_use = CW'(pc_reg);
        end
    end

    // Restoring divide step: t = floor(i * 65536 / segment_count)
    assign rem_sh  = {rem_reg, dvd_reg[bdc_pkg::DIV_STEPS-1]};
    assign rem_sub = rem_sh - {1'b0, seg_reg};
    assign q_bit   = (rem_sh >= {1'b0, seg_reg});
    assign t_s     = signed'({1'b0, dvd_reg[bdc_pkg::T_BITS-1:0]});

    // Memories
    assign ctrl_rd_addr = ((state_reg == bdc_pkg::S_LEVEL) && first_reg) ?
                          rd_cnt_reg[AW-1:0] : '0;

    bdc_ram #(
        .WIDTH (RW),
        .DEPTH (MAX_POINTS)
    ) u_ctrl_ram (
        .clk     (clk),
        .wr_en   (in_acc && (kind == bdc_pkg::KIND_LOAD) && slot_ok),
        .wr_addr (AW'(point_index)),
        .wr_data ({point_x, point_y}),
        .rd_addr (ctrl_rd_addr),
        .rd_data (ctrl_rd)
    );

    bdc_ram #(
        .WIDTH (RW),
        .DEPTH (MAX_POINTS)
    ) u_work_ram (
        .clk     (clk),
        .wr_en   (v3_reg),
        .wr_addr (idx3_reg),
        .wr_data (work_wr),
        .rd_addr (rd_cnt_reg[AW-1:0]),
        .rd_data (work_rd)
    );

    assign src_rd = first_reg ? ctrl_rd : work_rd;
    assign src_x  = signed'(src_rd[RW-1 -: COORD_BITS]);
    assign src_y  = signed'(src_rd[COORD_BITS-1:0]);

    // Lerp tail: a + floor(((b - a) * t + half) / 65536)
    assign sum_x   = px_reg + ROUND_HALF;
    assign sum_y   = py_reg + ROUND_HALF;
    assign wide_x  = (sum_x >>> bdc_pkg::T_FRAC_BITS)
                     + {{(PW-COORD_BITS){ah2x_reg[COORD_BITS-1]}}, ah2x_reg};
    assign wide_y  = (sum_y >>> bdc_pkg::T_FRAC_BITS)
                     + {{(PW-COORD_BITS){ah2y_reg[COORD_BITS-1]}}, ah2y_reg};
    assign lerp_x  = wide_x[COORD_BITS-1:0];
    assign lerp_y  = wide_y[COORD_BITS-1:0];
    assign work_wr = {lerp_x, lerp_y};

    // Sequencer
    always_comb
    begin
        state_next   = state_reg;
        lvl_next     = lvl_reg;
        rd_cnt_next  = rd_cnt_reg;
        first_next   = first_reg;
        div_cnt_next = div_cnt_reg;
        dvd_next     = dvd_reg;
        rem_next     = rem_reg;
        res_x_next   = res_x_reg;
        res_y_next   = res_y_reg;
        res_st_next  = res_st_reg;
        issue        = 1'b0;
        case (state_reg)
            bdc_pkg::S_IDLE:
            begin
                if (in_acc && (kind == bdc_pkg::KIND_SAMPLE))
                begin
                    if ((n_use == '0) || (seg_reg == '0))
                    begin
                        res_x_next  = '0;
                        res_y_next  = '0;
                        res_st_next = bdc_pkg::STATUS_NO_CURVE;
                        state_next  = bdc_pkg::S_FINISH;
                    end
                    else if ((sample_index > seg_reg) ||
                             ((n_use == CW'(1)) && (sample_index != '0)))
                    begin
                        res_x_next  = '0;
                        res_y_next  = '0;
                        res_st_next = bdc_pkg::STATUS_RANGE;
                        state_next  = bdc_pkg::S_FINISH;
                    end
                    else if (n_use == CW'(1))
                    begin
                        state_next = bdc_pkg::S_SINGLE;
                    end
                    else
                    begin
                        dvd_next     = {sample_index, {bdc_pkg::T_FRAC_BITS{1'b0}}};
                        rem_next     = '0;
                        div_cnt_next = bdc_pkg::DIV_CNT_BITS'(bdc_pkg::DIV_STEPS);
                        lvl_next     = n_use;
                        rd_cnt_next  = '0;
                        first_next   = 1'b1;
                        state_next   = bdc_pkg::S_DIV;
                    end
                end
            end
            bdc_pkg::S_DIV:
            begin
                dvd_next     = {dvd_reg[bdc_pkg::DIV_STEPS-2:0], q_bit};
                rem_next     = q_bit ? rem_sub[bdc_pkg::SEG_BITS-1:0]
                                     : rem_sh[bdc_pkg::SEG_BITS-1:0];
                div_cnt_next = div_cnt_reg - 1'b1;
                if (div_cnt_reg == bdc_pkg::DIV_CNT_BITS'(1))
                begin
                    state_next = bdc_pkg::S_LEVEL;
                end
            end
            bdc_pkg::S_LEVEL:
            begin
                if (rd_cnt_reg != lvl_reg)
                begin
                    issue       = 1'b1;
                    rd_cnt_next = rd_cnt_reg + 1'b1;
                end
                else if (!v1_reg && !v2_reg && !v3_reg)
                begin
                    // level drained: either the last point is out, or shrink by one
                    if (lvl_reg == CW'(2))
                    begin
                        res_x_next  = last_x_reg;
                        res_y_next  = last_y_reg;
                        res_st_next = bdc_pkg::STATUS_OK;
                        state_next  = bdc_pkg::S_FINISH;
                    end
                    else
                    begin
                        lvl_next    = lvl_reg - 1'b1;
                        rd_cnt_next = '0;
                        first_next  = 1'b0;
                    end
                end
            end
            bdc_pkg::S_SINGLE:
            begin
                res_x_next  = signed'(ctrl_rd[RW-1 -: COORD_BITS]);
                res_y_next  = signed'(ctrl_rd[COORD_BITS-1:0]);
                res_st_next = bdc_pkg::STATUS_OK;
                state_next  = bdc_pkg::S_FINISH;
            end
            bdc_pkg::S_FINISH:
            begin
                if (deliver)
                begin
                    state_next = bdc_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = bdc_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bdc_pkg::S_IDLE;
            seg_reg       <= bdc_pkg::SEG_BITS'(bdc_pkg::SEG_RESET);
            pc_reg        <= '0;
            lvl_reg       <= '0;
            rd_cnt_reg    <= '0;
            first_reg     <= 1'b0;
            div_cnt_reg   <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            lvl_reg     <= lvl_next;
            rd_cnt_reg  <= rd_cnt_next;
            first_reg   <= first_next;
            div_cnt_reg <= div_cnt_next;
            v1_reg      <= issue;
            v2_reg      <= v1_reg && (idx1_reg != '0);
            v3_reg      <= v2_reg;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    bdc_pkg::CFG_SEGMENT_COUNT: seg_reg <= cfg_data[bdc_pkg::SEG_BITS-1:0];
                    bdc_pkg::CFG_POINT_COUNT:   pc_reg  <= cfg_data[bdc_pkg::PC_BITS-1:0];
                    default:                    ;
                endcase
            end
            if (deliver)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg    <= dvd_next;
        rem_reg    <= rem_next;
        res_x_reg  <= res_x_next;
        res_y_reg  <= res_y_next;
        res_st_reg <= res_st_next;
        idx1_reg   <= rd_cnt_reg[AW-1:0];
        // stage 1: hold b as next a, form b - a
        if (v1_reg)
        begin
            ax_reg   <= src_x;
            ay_reg   <= src_y;
            ahx_reg  <= ax_reg;
            ahy_reg  <= ay_reg;
            dx_reg   <= {src_x[COORD_BITS-1], src_x} - {ax_reg[COORD_BITS-1], ax_reg};
            dy_reg   <= {src_y[COORD_BITS-1], src_y} - {ay_reg[COORD_BITS-1], ay_reg};
            idx2_reg <= idx1_reg - AW'(1);
        end
        // stage 2: multiply by t
        px_reg   <= dx_reg * t_s;
        py_reg   <= dy_reg * t_s;
        ah2x_reg <= ahx_reg;
        ah2y_reg <= ahy_reg;
        idx3_reg <= idx2_reg;
        // stage 3: round, add a, write back
        if (v3_reg)
        begin
            last_x_reg <= lerp_x;
            last_y_reg <= lerp_y;
        end
        if (deliver)
        begin
            out_x_reg  <= res_x_reg;
            out_y_reg  <= res_y_reg;
            out_st_reg <= res_st_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign curve_x   = out_x_reg;
    assign curve_y   = out_y_reg;
    assign status    = out_st_reg;

    `BDC_ASSERT(a_wb_in_level, clk, rst_n, v3_reg |-> (state_reg == bdc_pkg::S_LEVEL), "lerp write outside level pass")
    `BDC_ASSERT(a_rd_bound, clk, rst_n, (state_reg == bdc_pkg::S_LEVEL) |-> ((rd_cnt_reg <= lvl_reg) && (lvl_reg >= CW'(2))), "level read counter out of bounds")
    `BDC_ASSERT(a_t_range, clk, rst_n, (state_reg == bdc_pkg::S_LEVEL) |-> (dvd_reg <= bdc_pkg::DIV_STEPS'(bdc_pkg::ONE_Q16)), "interpolation parameter above one")
    `BDC_ASSERT(a_finish_out, clk, rst_n, deliver |=> (out_valid_reg && (state_reg == bdc_pkg::S_IDLE)), "finished sample not presented")
    `BDC_ASSERT_NORST(a_reset_quiet, clk, (!rst_n) |=> !out_valid_reg, "result valid right after reset")

endmodule
